@@ design/dpb_pkg.sv @@
package dpb_pkg;

  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 24;
  localparam int RecipW    = 24;
  localparam int CenterW   = 9;
  localparam int DepthW    = 16;
  localparam int ColourW   = 8;
  localparam int CoordOutW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgInvDepthScale = 3'd0,
    CfgCenterX       = 3'd1,
    CfgCenterY       = 3'd2,
    CfgInvFocalX     = 3'd3,
    CfgInvFocalY     = 3'd4
  } cfg_idx_e;

  localparam logic [RecipW-1:0]  ResetInvDepthScale = 24'd23967;
  localparam logic [CenterW-1:0] ResetCenterX       = 9'd256;
  localparam logic [CenterW-1:0] ResetCenterY       = 9'd212;
  localparam logic [RecipW-1:0]  ResetInvFocalX     = 24'd46218;
  localparam logic [RecipW-1:0]  ResetInvFocalY     = 24'd46218;

  typedef struct packed {
    logic [RecipW-1:0]  inv_depth_scale;
    logic [CenterW-1:0] center_x;
    logic [CenterW-1:0] center_y;
    logic [RecipW-1:0]  inv_focal_x;
    logic [RecipW-1:0]  inv_focal_y;
  } dpb_cfg_t;

  // Load enables of the five pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } dpb_en_t;

endpackage

@@ design/dpb_cfg.sv @@
module dpb_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [dpb_pkg::CfgIdxW-1:0]   wr_index_i,
  input  logic [dpb_pkg::CfgDataW-1:0]  wr_data_i,
  output dpb_pkg::dpb_cfg_t             cfg_o
);

  dpb_pkg::dpb_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_depth_scale <= dpb_pkg::ResetInvDepthScale;
      cfg_q.center_x        <= dpb_pkg::ResetCenterX;
      cfg_q.center_y        <= dpb_pkg::ResetCenterY;
      cfg_q.inv_focal_x     <= dpb_pkg::ResetInvFocalX;
      cfg_q.inv_focal_y     <= dpb_pkg::ResetInvFocalY;
    end else if (wr_en_i) begin
      case (dpb_pkg::cfg_idx_e'(wr_index_i))
        dpb_pkg::CfgInvDepthScale: cfg_q.inv_depth_scale <= wr_data_i;
        dpb_pkg::CfgCenterX:       cfg_q.center_x <= wr_data_i[dpb_pkg::CenterW-1:0];
        dpb_pkg::CfgCenterY:       cfg_q.center_y <= wr_data_i[dpb_pkg::CenterW-1:0];
        dpb_pkg::CfgInvFocalX:     cfg_q.inv_focal_x <= wr_data_i;
        dpb_pkg::CfgInvFocalY:     cfg_q.inv_focal_y <= wr_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/dpb_axis.sv @@
module dpb_axis #(
  parameter int CoordBits = 9
) (
  input  logic                            clk_i,
  input  dpb_pkg::dpb_en_t                en_i,
  input  logic [CoordBits-1:0]            pos_i,
  input  logic [CoordBits-1:0]            center_i,
  input  logic [dpb_pkg::RecipW-1:0]      recip_i,
  input  logic [dpb_pkg::CoordOutW-1:0]   z_i,
  output logic [dpb_pkg::CoordOutW-1:0]   coord_o
);

  localparam int PW = CoordBits + dpb_pkg::RecipW;
  localparam int AW = PW + 16;
  localparam int SW = AW + 17;
  localparam int RW = SW - 24;

  logic                 neg1_q, neg2_q, neg3_q, neg4_q;
  logic [CoordBits-1:0] mag_q, mag_d;
  logic [PW-1:0]        p_q, p_d;
  logic [AW-1:0]        a_q, a_d, b_q, b_d;
  logic [SW-1:0]        sum;
  logic [RW-1:0]        r_q, r_d;
  logic                 big;
  logic [dpb_pkg::CoordOutW-1:0] coord_q, coord_d;

  assign mag_d = (pos_i < center_i) ? (center_i - pos_i) : (pos_i - center_i);
  assign p_d   = PW'(mag_q) * PW'(recip_i);
  assign a_d   = AW'(p_q) * AW'(z_i[31:16]);
  assign b_d   = AW'(p_q) * AW'(z_i[15:0]);

  // The full product p*z is rebuilt from its two halves and rounded half up at bit 23.
  assign sum = (SW'(a_q) << 16) + SW'(b_q) + (SW'(1) << 23);
  assign r_d = sum[SW-1:24];

  assign big = |r_q[RW-1:31];
  always_comb begin
    if (neg4_q) begin
      coord_d = big ? 32'h8000_0000 : (32'd0 - r_q[31:0]);
    end else begin
      coord_d = big ? 32'h7FFF_FFFF : r_q[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      mag_q  <= mag_d;
      neg1_q <= pos_i < center_i;
    end
    if (en_i.s2) begin
      p_q    <= p_d;
      neg2_q <= neg1_q;
    end
    if (en_i.s3) begin
      a_q    <= a_d;
      b_q    <= b_d;
      neg3_q <= neg2_q;
    end
    if (en_i.s4) begin
      r_q    <= r_d;
      neg4_q <= neg3_q;
    end
    if (en_i.s5) begin
      coord_q <= coord_d;
    end
  end

  assign coord_o = coord_q;

endmodule

@@ design/depth_pixel_backprojection.sv @@
// Back-projects one depth pixel through a pinhole camera model to a coloured
// 3-D point in Q16.16 metres (X and Y signed, Z unsigned).
// Input channel: in_valid_i with the depth, row, column and colour fields;
// the block holds off transfers with in_stall_o. Output channel: out_valid_o
// with point and colour fields; the receiver holds off with out_stall_i.
// A pixel with zero depth is taken and yields no point.
// Configuration: cfg_valid_i with cfg_index_i and cfg_data_i; cfg_ready_o is
// always high. Write registers only while no pixels are in flight.
// Throughput: one pixel per cycle while the receiver does not stall, through
// five register stages (depth product, rounding and offset products, split Z
// products, wide sum, saturation). Empty stages close up, so zero-depth pixels
// leave no gaps. When the receiver stalls, stages fill up and in_stall_o rises
// only once all five stages hold a point. Reset empties the pipeline and loads
// the register defaults.
module depth_pixel_backprojection #(
  parameter int COORD_BITS = 9
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_index_i,
  input  logic [23:0]            cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [15:0]            depth_raw_i,
  input  logic [COORD_BITS-1:0]  pixel_row_i,
  input  logic [COORD_BITS-1:0]  pixel_col_i,
  input  logic [7:0]             blue_in_i,
  input  logic [7:0]             green_in_i,
  input  logic [7:0]             red_in_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [31:0]     point_x_o,
  output logic signed [31:0]     point_y_o,
  output logic [31:0]            point_z_o,
  output logic [7:0]             blue_out_o,
  output logic [7:0]             green_out_o,
  output logic [7:0]             red_out_o
);

  localparam int NumStages = 5;
  localparam int ColW      = 3 * dpb_pkg::ColourW;

  dpb_pkg::dpb_cfg_t cfg;
  dpb_pkg::dpb_en_t  en;

  logic [NumStages:1] valid_q;
  logic [NumStages:1] rdy;
  logic               enter;

  logic [39:0] zprod_q;
  logic [40:0] zsum;
  logic [32:0] zshift;
  logic [31:0] z_d, z2_q, z3_q, z4_q, z5_q;
  logic [ColW-1:0] col1_q, col2_q, col3_q, col4_q, col5_q;
  logic [31:0] px, py;

  assign cfg_ready_o = 1'b1;

  dpb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // A stage may load when it is empty or its content moves on in the same cycle.
  assign rdy[NumStages] = !valid_q[NumStages] || !out_stall_i;
  for (genvar k = 1; k < NumStages; k++) begin : g_rdy
    assign rdy[k] = !valid_q[k] || rdy[k+1];
  end

  assign en.s1 = rdy[1];
  assign en.s2 = rdy[2];
  assign en.s3 = rdy[3];
  assign en.s4 = rdy[4];
  assign en.s5 = rdy[5];

  assign in_stall_o = !rdy[1];
  assign enter      = in_valid_i && (depth_raw_i != 16'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[1]) begin
        valid_q[1] <= enter;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Z is rounded half up from Q16.24 to Q16.16 and clamped to 32 bits.
  assign zsum   = 41'(zprod_q) + 41'h80;
  assign zshift = zsum[40:8];
  assign z_d    = zshift[32] ? 32'hFFFF_FFFF : zshift[31:0];

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      zprod_q <= 40'(depth_raw_i) * 40'(cfg.inv_depth_scale);
      col1_q  <= {blue_in_i, green_in_i, red_in_i};
    end
    if (en.s2) begin
      z2_q   <= z_d;
      col2_q <= col1_q;
    end
    if (en.s3) begin
      z3_q   <= z2_q;
      col3_q <= col2_q;
    end
    if (en.s4) begin
      z4_q   <= z3_q;
      col4_q <= col3_q;
    end
    if (en.s5) begin
      z5_q   <= z4_q;
      col5_q <= col4_q;
    end
  end

  dpb_axis #(
    .CoordBits (COORD_BITS)
  ) u_axis_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .pos_i    (pixel_col_i),
    .center_i (COORD_BITS'(cfg.center_x)),
    .recip_i  (cfg.inv_focal_x),
    .z_i      (z2_q),
    .coord_o  (px)
  );

  dpb_axis #(
    .CoordBits (COORD_BITS)
  ) u_axis_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .pos_i    (pixel_row_i),
    .center_i (COORD_BITS'(cfg.center_y)),
    .recip_i  (cfg.inv_focal_y),
    .z_i      (z2_q),
    .coord_o  (py)
  );

  assign out_valid_o = valid_q[NumStages];
  assign point_x_o   = px;
  assign point_y_o   = py;
  assign point_z_o   = z5_q;
  assign blue_out_o  = col5_q[ColW-1:2*dpb_pkg::ColourW];
  assign green_out_o = col5_q[2*dpb_pkg::ColourW-1:dpb_pkg::ColourW];
  assign red_out_o   = col5_q[dpb_pkg::ColourW-1:0];

`ifndef NO_ASSERTIONS
  a_nonzero_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && depth_raw_i != 16'd0) |=> valid_q[1])
    else $error("accepted pixel with depth did not enter the pipeline");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input held off while a pipeline stage is empty");

  a_zero_depth_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && depth_raw_i == 16'd0) |=> !valid_q[1])
    else $error("zero-depth pixel entered the pipeline");
`endif

endmodule

@@ test/tb.sv @@
module tb;

  localparam int CfgIdxW  = dpb_pkg::CfgIdxW;
  localparam int CfgDataW = dpb_pkg::CfgDataW;
  localparam int CenterW  = dpb_pkg::CenterW;
  localparam int DepthW   = dpb_pkg::DepthW;
  localparam int RecipW   = dpb_pkg::RecipW;

  localparam int DrainCycles   = 8;
  localparam int LongHoldCycles = 60;

  // Indexes past the last register; writes to them must leave the camera alone.
  localparam logic [CfgIdxW-1:0] SpareIdxFirst = 3'd5;
  localparam logic [CfgIdxW-1:0] SpareIdxLast  = 3'd7;

  typedef struct packed {
    logic [DepthW-1:0]  depth;
    logic [CenterW-1:0] row;
    logic [CenterW-1:0] col;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [31:0]        z;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
  } point_t;

  typedef enum logic [1:0] {RowPredicted, RowTyped, RowNoPoint, RowRegWrite} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CfgIdxW-1:0]    reg_idx;
    logic [CfgDataW-1:0]   reg_data;
    pixel_t                px;
    point_t                pt;
  } stim_row_t;

  typedef enum {CamMinimum, CamMaximum, CamRealistic, CamWild} cam_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i = dpb_pkg::CfgInvDepthScale;
  logic [CfgDataW-1:0]   cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [DepthW-1:0]     depth_raw_i = '0;
  logic [CenterW-1:0]    pixel_row_i = '0;
  logic [CenterW-1:0]    pixel_col_i = '0;
  logic [7:0]            blue_in_i = '0;
  logic [7:0]            green_in_i = '0;
  logic [7:0]            red_in_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [31:0]    point_x_o;
  logic signed [31:0]    point_y_o;
  logic [31:0]           point_z_o;
  logic [7:0]            blue_out_o;
  logic [7:0]            green_out_o;
  logic [7:0]            red_out_o;

  dpb_pkg::dpb_cfg_t cam;
  point_t   pending_points[$];
  stim_row_t stim_table[$];
  int       mismatch_count = 0;
  int       gap_odds = 4;
  bit       idle_off = 1'b0;
  bit       long_hold = 1'b0;
  bit       long_hold_active = 1'b0;

  depth_pixel_backprojection DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .depth_raw_i (depth_raw_i),
    .pixel_row_i (pixel_row_i),
    .pixel_col_i (pixel_col_i),
    .blue_in_i   (blue_in_i),
    .green_in_i  (green_in_i),
    .red_in_i    (red_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o),
    .point_z_o   (point_z_o),
    .blue_out_o  (blue_out_o),
    .green_out_o (green_out_o),
    .red_out_o   (red_out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2000000;
    $display("depth_pixel_backprojection test failed");
    $finish;
  end

  // Offset from the principal point times Z times the reciprocal focal length,
  // rounded half away from zero and saturated. The product is split on Z so
  // that nothing overflows 64 bits.
  function automatic logic [31:0] offset_metres(input logic [CenterW-1:0] pos,
                                                input logic [CenterW-1:0] ctr,
                                                input logic [RecipW-1:0] recip,
                                                input logic [31:0] z);
    logic        below;
    logic [63:0] mag;
    logic [63:0] p;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] r;
    below = pos < ctr;
    mag = below ? 64'(ctr) - 64'(pos) : 64'(pos) - 64'(ctr);
    p = mag * 64'(recip);
    hi = p * 64'(z[31:16]);
    lo = p * 64'(z[15:0]) + (64'd1 << 23);
    r = (hi >> 8) + ((((hi & 64'hFF) << 16) + lo) >> 24);
    if (below) begin
      return (r >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - r[31:0];
    end
    return (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
  endfunction

  function automatic bit back_project(input pixel_t px, input dpb_pkg::dpb_cfg_t c,
                                      output point_t pt);
    logic [63:0] zp;
    logic [31:0] z;
    pt = '0;
    if (px.depth == '0) return 1'b0;
    zp = (64'(px.depth) * 64'(c.inv_depth_scale) + 64'h80) >> 8;
    z = (zp > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : zp[31:0];
    pt.x = offset_metres(px.col, c.center_x, c.inv_focal_x, z);
    pt.y = offset_metres(px.row, c.center_y, c.inv_focal_y, z);
    pt.z = z;
    pt.blue = px.blue;
    pt.green = px.green;
    pt.red = px.red;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : point_checker
    point_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_points.size() == 0) begin
        flag_mismatch("point transferred with no pixel waiting for one");
      end else begin
        want = pending_points.pop_front();
        if (point_x_o !== want.x)
          flag_mismatch($sformatf("point_x %h, expected %h", point_x_o, want.x));
        if (point_y_o !== want.y)
          flag_mismatch($sformatf("point_y %h, expected %h", point_y_o, want.y));
        if (point_z_o !== want.z)
          flag_mismatch($sformatf("point_z %h, expected %h", point_z_o, want.z));
        if (blue_out_o !== want.blue)
          flag_mismatch($sformatf("blue %h, expected %h", blue_out_o, want.blue));
        if (green_out_o !== want.green)
          flag_mismatch($sformatf("green %h, expected %h", green_out_o, want.green));
        if (red_out_o !== want.red)
          flag_mismatch($sformatf("red %h, expected %h", red_out_o, want.red));
      end
    end
  end

  // Receiver: random stall bursts, free-running stretches, and one long hold-off
  // on request so that the pipeline fills and pushes back on the input.
  initial begin : point_sink
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        long_hold_active = 1'b1;
        repeat (LongHoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        long_hold = 1'b0;
        long_hold_active = 1'b0;
      end else if (!idle_off && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        repeat ($urandom_range(0, 39)) @(posedge clk_i);
      end
    end
  end

  function automatic pixel_t pixel(input logic [DepthW-1:0] d, input logic [CenterW-1:0] r,
                                   input logic [CenterW-1:0] c, input logic [7:0] b,
                                   input logic [7:0] g, input logic [7:0] rd);
    pixel_t px;
    px.depth = d;
    px.row = r;
    px.col = c;
    px.blue = b;
    px.green = g;
    px.red = rd;
    return px;
  endfunction

  function automatic stim_row_t predicted_row(input pixel_t px);
    stim_row_t row;
    row = '0;
    row.kind = RowPredicted;
    row.px = px;
    return row;
  endfunction

  function automatic stim_row_t no_point_row(input pixel_t px);
    stim_row_t row;
    row = predicted_row(px);
    row.kind = RowNoPoint;
    return row;
  endfunction

  function automatic stim_row_t typed_row(input pixel_t px, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z);
    stim_row_t row;
    row = predicted_row(px);
    row.kind = RowTyped;
    row.pt.x = x;
    row.pt.y = y;
    row.pt.z = z;
    row.pt.blue = px.blue;
    row.pt.green = px.green;
    row.pt.red = px.red;
    return row;
  endfunction

  function automatic stim_row_t write_row(input logic [CfgIdxW-1:0] idx,
                                          input logic [CfgDataW-1:0] data);
    stim_row_t row;
    row = '0;
    row.kind = RowRegWrite;
    row.reg_idx = idx;
    row.reg_data = data;
    return row;
  endfunction

  task automatic add_row(input stim_row_t row);
    stim_table = {stim_table, row};
  endtask

  function automatic logic [CenterW-1:0] pick_coord(input logic [CenterW-1:0] ctr);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return ctr;
      default: return CenterW'($urandom);
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    case ($urandom_range(0, 9))
      0: px.depth = '0;
      1: px.depth = '1;
      2: px.depth = DepthW'($urandom_range(1, 255));
      default: px.depth = DepthW'($urandom);
    endcase
    px.row = pick_coord(cam.center_y);
    px.col = pick_coord(cam.center_x);
    px.blue = 8'($urandom);
    px.green = 8'($urandom);
    px.red = 8'($urandom);
    return px;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_reg(input int idx, input cam_mode_e mode);
    logic [CfgDataW-1:0] noise;
    bit                  is_centre;
    noise = CfgDataW'($urandom);
    is_centre = (idx == dpb_pkg::CfgCenterX) || (idx == dpb_pkg::CfgCenterY);
    case (mode)
      CamMinimum: return is_centre ? (noise & ~24'h1FF) : 24'd1;
      CamMaximum: return is_centre ? (noise | 24'h1FF) : 24'hFF_FFFF;
      CamRealistic: begin
        if (is_centre) return noise;
        if (idx == dpb_pkg::CfgInvDepthScale) return CfgDataW'($urandom_range(8000, 70000));
        return CfgDataW'($urandom_range(20000, 120000));
      end
      default: return noise;
    endcase
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      dpb_pkg::CfgInvDepthScale: cam.inv_depth_scale = data;
      dpb_pkg::CfgCenterX:       cam.center_x = data[CenterW-1:0];
      dpb_pkg::CfgCenterY:       cam.center_y = data[CenterW-1:0];
      dpb_pkg::CfgInvFocalX:     cam.inv_focal_x = data;
      dpb_pkg::CfgInvFocalY:     cam.inv_focal_y = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every point to come out, then let the pipeline drain before the
  // camera is touched.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic offer_pixel(input stim_row_t row);
    point_t pt;
    bit     has_pt;
    in_valid_i <= 1'b1;
    depth_raw_i <= row.px.depth;
    pixel_row_i <= row.px.row;
    pixel_col_i <= row.px.col;
    blue_in_i <= row.px.blue;
    green_in_i <= row.px.green;
    red_in_i <= row.px.red;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    has_pt = back_project(row.px, cam, pt);
    case (row.kind)
      RowTyped: pending_points = {pending_points, row.pt};
      RowPredicted: if (has_pt) pending_points = {pending_points, pt};
      default: ;
    endcase
    if (!idle_off && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  initial begin : pixel_source
    cam_mode_e mode;
    cam.inv_depth_scale = dpb_pkg::ResetInvDepthScale;
    cam.center_x = dpb_pkg::ResetCenterX;
    cam.center_y = dpb_pkg::ResetCenterY;
    cam.inv_focal_x = dpb_pkg::ResetInvFocalX;
    cam.inv_focal_y = dpb_pkg::ResetInvFocalY;

    // Reset camera: centred pixels land on the optical axis.
    add_row(typed_row(pixel(16'd1, 9'd212, 9'd256, 8'h00, 8'h00, 8'h00),
                      32'd0, 32'd0, 32'd94));
    add_row(typed_row(pixel(16'hFFFF, 9'd212, 9'd256, 8'hFF, 8'hFF, 8'hFF),
                      32'd0, 32'd0, 32'd6135458));
    add_row(no_point_row(pixel(16'd0, 9'd511, 9'd511, 8'hA5, 8'h5A, 8'hC3)));
    add_row(predicted_row(pixel(16'd1000, 9'd0, 9'd0, 8'h01, 8'h80, 8'h7F)));
    add_row(predicted_row(pixel(16'hFFFF, 9'd511, 9'd511, 8'h10, 8'h20, 8'h30)));
    add_row(predicted_row(pixel(16'hFFFF, 9'd0, 9'd0, 8'hFE, 8'hEF, 8'h55)));
    add_row(predicted_row(pixel(16'h8000, 9'd100, 9'd300, 8'h12, 8'h34, 8'h56)));
    add_row(predicted_row(pixel(16'h7FFF, 9'd300, 9'd100, 8'hAA, 8'h55, 8'h0F)));
    add_row(no_point_row(pixel(16'd0, 9'd0, 9'd0, 8'h00, 8'hFF, 8'h00)));
    // Largest reciprocals and centres at opposite corners: both axes saturate.
    add_row(write_row(dpb_pkg::CfgInvDepthScale, 24'hFF_FFFF));
    add_row(write_row(dpb_pkg::CfgCenterX, 24'h00_0000));
    add_row(write_row(dpb_pkg::CfgCenterY, 24'h00_01FF));
    add_row(write_row(dpb_pkg::CfgInvFocalX, 24'hFF_FFFF));
    add_row(write_row(dpb_pkg::CfgInvFocalY, 24'hFF_FFFF));
    add_row(write_row(SpareIdxFirst, 24'h00_0000));
    add_row(write_row(SpareIdxLast, 24'h00_0000));
    add_row(typed_row(pixel(16'hFFFF, 9'd0, 9'd511, 8'h3C, 8'hC3, 8'h99),
                      32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFE_FF00));
    add_row(predicted_row(pixel(16'd1, 9'd511, 9'd0, 8'h01, 8'h02, 8'h03)));
    add_row(predicted_row(pixel(16'd1, 9'd0, 9'd511, 8'h04, 8'h05, 8'h06)));
    add_row(predicted_row(pixel(16'hFFFF, 9'd511, 9'd0, 8'h07, 8'h08, 8'h09)));
    add_row(no_point_row(pixel(16'd0, 9'd0, 9'd511, 8'hFF, 8'h00, 8'hFF)));
    // A zero reciprocal simply zeroes what it scales.
    add_row(write_row(dpb_pkg::CfgInvDepthScale, 24'h00_0000));
    add_row(typed_row(pixel(16'hFFFF, 9'd0, 9'd0, 8'h11, 8'h22, 8'h33),
                      32'd0, 32'd0, 32'd0));
    // Centre writes carry junk above bit 8; only the low bits count.
    add_row(write_row(dpb_pkg::CfgInvDepthScale, dpb_pkg::ResetInvDepthScale));
    add_row(write_row(dpb_pkg::CfgInvFocalX, 24'h00_0000));
    add_row(write_row(dpb_pkg::CfgInvFocalY, 24'h00_0000));
    add_row(write_row(dpb_pkg::CfgCenterX, 24'hAB_C100));
    add_row(write_row(dpb_pkg::CfgCenterY, 24'h5A_50D4));
    add_row(typed_row(pixel(16'hFFFF, 9'd0, 9'd511, 8'h44, 8'h55, 8'h66),
                      32'd0, 32'd0, 32'd6135458));
    add_row(predicted_row(pixel(16'd300, 9'd17, 9'd400, 8'h77, 8'h88, 8'h99)));
    add_row(write_row(dpb_pkg::CfgInvFocalX, dpb_pkg::ResetInvFocalX));
    add_row(write_row(dpb_pkg::CfgInvFocalY, dpb_pkg::ResetInvFocalY));
    add_row(predicted_row(pixel(16'd2000, 9'd212, 9'd0, 8'hBB, 8'hCC, 8'hDD)));

    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == RowRegWrite) begin
        settle();
        write_reg(stim_table[i].reg_idx, stim_table[i].reg_data);
      end else begin
        offer_pixel(stim_table[i]);
      end
    end
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) mode = CamMinimum;
      else if (phase == 1) mode = CamMaximum;
      else mode = cam_mode_e'($urandom_range(CamRealistic, CamWild));
      for (int idx = dpb_pkg::CfgInvDepthScale; idx <= dpb_pkg::CfgInvFocalY; idx++)
        write_reg(CfgIdxW'(idx), pick_reg(idx, mode));
      write_reg(CfgIdxW'($urandom_range(SpareIdxFirst, SpareIdxLast)), CfgDataW'($urandom));
      gap_odds = $urandom_range(0, 6);
      if (phase == 3) begin
        // Keep offering pixels back to back while the receiver holds off.
        long_hold = 1'b1;
        while (!long_hold_active) @(posedge clk_i);
        gap_odds = 0;
        repeat (40) offer_pixel(predicted_row(random_pixel()));
        gap_odds = 3;
      end
      repeat (55) offer_pixel(predicted_row(random_pixel()));
      settle();
    end

    idle_off = 1'b1;
    repeat (80) offer_pixel(predicted_row(random_pixel()));
    settle();

    if (mismatch_count == 0) begin
      $display("depth_pixel_backprojection test passed");
    end else begin
      $display("depth_pixel_backprojection test failed");
    end
    $finish;
  end

endmodule
